>>> rtl/core/tlrg_pkg.sv
// Shared types, widths and register codes of the thin-lens ray generator.
// Used by the square-root cell, the divider cell and the top level.
package tlrg_pkg;

  localparam int COORD_BITS_DEF = 32;

  localparam int MAG_W  = 51;  // magnitude of a direction component, Q16.32
  localparam int NRM_W  = 30;  // normalised magnitude, top bit at 2^29
  localparam int SQ_W   = 62;  // sum of three squares
  localparam int ROOT_W = 31;  // floor square root of the sum
  localparam int NUM_W  = 48;  // dividend and remainder of the divide chain
  localparam int Q_W    = 17;  // quotient, at most 32768

  typedef enum logic [2:0] {
    REG_CAM_POS_X      = 3'd0,
    REG_CAM_POS_Y      = 3'd1,
    REG_CAM_POS_Z      = 3'd2,
    REG_VIEWPORT_W     = 3'd3,
    REG_VIEWPORT_H     = 3'd4,
    REG_FOCUS_DISTANCE = 3'd5,
    REG_LENS_RADIUS    = 3'd6,
    REG_SHUTTER_WINDOW = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [16:0]        pixel_u;
    logic [16:0]        pixel_v;
    logic signed [15:0] disk_x;
    logic signed [15:0] disk_y;
    logic [15:0]        time_sample;
  } ray_in_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [15:0]        ray_time;
  } ray_out_t;

  // fields that ride along with a ray through the normalise chain
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [15:0]        ray_time;
    logic [2:0]         neg;
    logic               zero;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0]             rem;
    logic [ROOT_W-1:0]           root;
    logic [2:0][NRM_W-1:0]       mag;
    side_t                       side;
  } sqrt_word_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0]       rem;
    logic [2:0][Q_W-1:0]         quo;
    logic [ROOT_W-1:0]           len;
    side_t                       side;
  } div_word_t;

endpackage

>>> rtl/core/tlrg_sqrt_cell.sv
// One bit of the square-root chain: decides root bit STEP and passes the word on.
// Depends on tlrg_pkg.
module tlrg_sqrt_cell
  import tlrg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_v,
  input  sqrt_word_t in_w,
  output logic       out_v,
  output sqrt_word_t out_w
);

  localparam int TW = SQ_W + 2;

  logic [TW-1:0] trial;
  logic          take;
  sqrt_word_t    w_nxt;
  logic          v_r;
  sqrt_word_t    w_r;

  // rem holds sum - root^2; setting this bit costs root*2^(STEP+1) + 4^STEP
  always_comb begin
    trial = (TW'(in_w.root) << (STEP + 1)) | (TW'(1) << (2 * STEP));
    take  = TW'(in_w.rem) >= trial;
    w_nxt = in_w;
    if (take) begin
      w_nxt.rem        = in_w.rem - trial[SQ_W-1:0];
      w_nxt.root[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign out_v = v_r;
  assign out_w = w_r;

endmodule

>>> rtl/core/tlrg_div_cell.sv
// One quotient bit of the three-lane divide chain (restoring division by len).
// Depends on tlrg_pkg.
module tlrg_div_cell
  import tlrg_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_v,
  input  div_word_t in_w,
  output logic      out_v,
  output div_word_t out_w
);

  logic [NUM_W-1:0] trial;
  div_word_t        w_nxt;
  logic             v_r;
  div_word_t        w_r;

  always_comb begin
    trial = NUM_W'(in_w.len) << STEP;
    w_nxt = in_w;
    for (int k = 0; k < 3; k++) begin
      if (in_w.rem[k] >= trial) begin
        w_nxt.rem[k]       = in_w.rem[k] - trial;
        w_nxt.quo[k][STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign out_v = v_r;
  assign out_w = w_r;

endmodule

>>> rtl/core/thin_lens_ray_generator_unit.sv
// Thin-lens camera ray generator, Q16.16. One word in, one ray out.
// Stages: 9 front stages, 31 square-root cells, 1 dividend stage, 17 divider
// cells, output register. Throughput: one word per cycle while en is high;
// the cell chains take a new word every cycle that the pipe is not frozen.
// Reset (synchronous, rst_n low) empties the pipe and loads register defaults.
// Depends on tlrg_pkg, tlrg_sqrt_cell and tlrg_div_cell.
module thin_lens_ray_generator_unit
  import tlrg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  ray_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ray_out_t    out_data
);

  localparam int CB = (COORD_BITS < 16) ? 16 : ((COORD_BITS > 32) ? 32 : COORD_BITS);
  localparam logic signed [34:0] SAT_HI = 35'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

  // configuration registers
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [30:0]        vp_w_r, vp_h_r, focus_r, lens_r;
  logic [31:0]        shutter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r   <= '0;
      cam_y_r   <= '0;
      cam_z_r   <= '0;
      vp_w_r    <= 31'd131072;
      vp_h_r    <= 31'd131072;
      focus_r   <= 31'd65536;
      lens_r    <= '0;
      shutter_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CAM_POS_X:      cam_x_r   <= cfg_wdata;
        REG_CAM_POS_Y:      cam_y_r   <= cfg_wdata;
        REG_CAM_POS_Z:      cam_z_r   <= cfg_wdata;
        REG_VIEWPORT_W:     vp_w_r    <= cfg_wdata[30:0];
        REG_VIEWPORT_H:     vp_h_r    <= cfg_wdata[30:0];
        REG_FOCUS_DISTANCE: focus_r   <= cfg_wdata[30:0];
        REG_LENS_RADIUS:    lens_r    <= cfg_wdata[30:0];
        REG_SHUTTER_WINDOW: shutter_r <= cfg_wdata;
      endcase
    end
  end

  // pipe control: freeze only when a ray reaches the end with the output full
  logic en;
  logic last_v;
  logic out_valid_r;

  assign en       = !(last_v && out_valid_r && out_stall);
  assign in_stall = !en;

  // ---- stage 1: products
  logic signed [17:0] u_c, v_c;
  logic signed [16:0] t_span;
  logic signed [47:0] prod_ox_nxt, prod_oy_nxt, prod_ox_r, prod_oy_r;
  logic signed [49:0] prod_w_nxt, prod_h_nxt, prod_w_r, prod_h_r;
  logic signed [33:0] prod_t_nxt, prod_t_r;
  logic               v1_r;

  always_comb begin
    u_c    = $signed({1'b0, in_data.pixel_u}) - 18'sd32768;
    v_c    = 18'sd32768 - $signed({1'b0, in_data.pixel_v});
    t_span = $signed({1'b0, shutter_r[15:0]}) - $signed({1'b0, shutter_r[31:16]});
    prod_ox_nxt = 48'(in_data.disk_x) * 48'($signed({1'b0, lens_r}));
    prod_oy_nxt = 48'(in_data.disk_y) * 48'($signed({1'b0, lens_r}));
    prod_w_nxt  = 50'(u_c) * 50'($signed({1'b0, vp_w_r}));
    prod_h_nxt  = 50'(v_c) * 50'($signed({1'b0, vp_h_r}));
    prod_t_nxt  = 34'($signed({1'b0, in_data.time_sample})) * 34'(t_span);
  end

  // ---- stage 2: round lens offset and ray time
  logic [47:0]        mox, moy;
  logic [32:0]        rox, roy;
  logic [33:0]        mt;
  logic [17:0]        rt;
  logic signed [33:0] offx_nxt, offy_nxt, offx_r, offy_r;
  logic [15:0]        tm_nxt, tm_r;
  logic signed [49:0] prod_w2_r, prod_h2_r;
  logic               v2_r;

  always_comb begin
    mox = prod_ox_r[47] ? 48'(-prod_ox_r) : 48'(prod_ox_r);
    moy = prod_oy_r[47] ? 48'(-prod_oy_r) : 48'(prod_oy_r);
    rox = 33'((mox + 48'd16384) >> 15);
    roy = 33'((moy + 48'd16384) >> 15);
    offx_nxt = prod_ox_r[47] ? -$signed({1'b0, rox}) : $signed({1'b0, rox});
    offy_nxt = prod_oy_r[47] ? -$signed({1'b0, roy}) : $signed({1'b0, roy});
    mt = prod_t_r[33] ? 34'(-prod_t_r) : 34'(prod_t_r);
    rt = 18'((mt + 34'd32768) >> 16);
    tm_nxt = prod_t_r[33] ? (shutter_r[31:16] - rt[15:0]) : (shutter_r[31:16] + rt[15:0]);
  end

  // ---- stage 3: origin with saturation, difference vector in Q16.32
  logic signed [34:0] sum_x, sum_y;
  side_t              side3_nxt, side3_r;
  logic signed [51:0] d_nxt [3];
  logic signed [51:0] d_r   [3];
  logic               v3_r;

  always_comb begin
    sum_x = 35'(cam_x_r) + 35'(offx_r);
    sum_y = 35'(cam_y_r) + 35'(offy_r);
    side3_nxt          = '0;
    side3_nxt.ray_time = tm_r;
    if (sum_x > SAT_HI)      side3_nxt.origin_x = SAT_HI[31:0];
    else if (sum_x < SAT_LO) side3_nxt.origin_x = SAT_LO[31:0];
    else                     side3_nxt.origin_x = sum_x[31:0];
    if (sum_y > SAT_HI)      side3_nxt.origin_y = SAT_HI[31:0];
    else if (sum_y < SAT_LO) side3_nxt.origin_y = SAT_LO[31:0];
    else                     side3_nxt.origin_y = sum_y[31:0];
    d_nxt[0] = 52'(prod_w2_r) - (52'(offx_r) <<< 16);
    d_nxt[1] = 52'(prod_h2_r) - (52'(offy_r) <<< 16);
    d_nxt[2] = -($signed({21'd0, focus_r}) <<< 16);
  end

  // ---- stage 4: magnitudes and signs
  logic [MAG_W-1:0] mag4_nxt [3];
  logic [MAG_W-1:0] mag4_r   [3];
  side_t            side4_nxt, side4_r;
  logic             v4_r;

  always_comb begin
    side4_nxt = side3_r;
    for (int k = 0; k < 3; k++) begin
      side4_nxt.neg[k] = d_r[k][51];
      mag4_nxt[k] = d_r[k][51] ? MAG_W'(-d_r[k]) : MAG_W'(d_r[k]);
    end
  end

  // ---- stage 5: leading one per byte group of the largest magnitude
  logic [55:0]      or_all;
  logic [6:0]       nz_nxt, nz_r;
  logic [6:0][2:0]  pos_nxt, pos_r;
  logic [MAG_W-1:0] mag5_r [3];
  side_t            side5_r;
  logic             v5_r;

  always_comb begin
    or_all = 56'(mag4_r[0] | mag4_r[1] | mag4_r[2]);
    for (int g = 0; g < 7; g++) begin
      nz_nxt[g]  = |or_all[g*8 +: 8];
      pos_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or_all[g*8 + b]) pos_nxt[g] = 3'(b);
      end
    end
  end

  // ---- stage 6: pick the top group
  logic [5:0]       lead_nxt, lead_r;
  side_t            side6_nxt, side6_r;
  logic [MAG_W-1:0] mag6_r [3];
  logic             v6_r;

  always_comb begin
    lead_nxt       = '0;
    side6_nxt      = side5_r;
    side6_nxt.zero = 1'b1;
    for (int g = 0; g < 7; g++) begin
      if (nz_r[g]) begin
        lead_nxt       = {3'(g), pos_r[g]};
        side6_nxt.zero = 1'b0;
      end
    end
  end

  // ---- stage 7: common shift so the largest lands in [2^29, 2^30)
  logic [NRM_W-1:0] nrm_nxt [3];
  logic [NRM_W-1:0] nrm_r   [3];
  side_t            side7_r;
  logic             v7_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lead_r >= 6'd29) nrm_nxt[k] = NRM_W'(mag6_r[k] >> (lead_r - 6'd29));
      else                 nrm_nxt[k] = NRM_W'(mag6_r[k] << (6'd29 - lead_r));
    end
  end

  // ---- stage 8: squares
  logic [2*NRM_W-1:0] sqr_r [3];
  logic [NRM_W-1:0]   nrm8_r [3];
  side_t              side8_r;
  logic               v8_r;

  // ---- stage 9: sum of squares, start of the root chain
  sqrt_word_t sq_nxt, sq_r;
  logic       v9_r;

  always_comb begin
    sq_nxt.rem  = SQ_W'(sqr_r[0]) + SQ_W'(sqr_r[1]) + SQ_W'(sqr_r[2]);
    sq_nxt.root = '0;
    for (int k = 0; k < 3; k++) sq_nxt.mag[k] = nrm8_r[k];
    sq_nxt.side = side8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ox_r <= prod_ox_nxt;
      prod_oy_r <= prod_oy_nxt;
      prod_w_r  <= prod_w_nxt;
      prod_h_r  <= prod_h_nxt;
      prod_t_r  <= prod_t_nxt;
      offx_r    <= offx_nxt;
      offy_r    <= offy_nxt;
      tm_r      <= tm_nxt;
      prod_w2_r <= prod_w_r;
      prod_h2_r <= prod_h_r;
      side3_r   <= side3_nxt;
      side4_r   <= side4_nxt;
      nz_r      <= nz_nxt;
      pos_r     <= pos_nxt;
      side5_r   <= side4_r;
      lead_r    <= lead_nxt;
      side6_r   <= side6_nxt;
      side7_r   <= side6_r;
      side8_r   <= side7_r;
      sq_r      <= sq_nxt;
      for (int k = 0; k < 3; k++) begin
        d_r[k]    <= d_nxt[k];
        mag4_r[k] <= mag4_nxt[k];
        mag5_r[k] <= mag4_r[k];
        mag6_r[k] <= mag5_r[k];
        nrm_r[k]  <= nrm_nxt[k];
        nrm8_r[k] <= nrm_r[k];
        sqr_r[k]  <= nrm_r[k] * nrm_r[k];
      end
    end
  end

  // ---- square-root chain, one root bit per cell, top bit first
  logic       sv   [ROOT_W+1];
  sqrt_word_t sw   [ROOT_W+1];

  assign sv[0] = v9_r;
  assign sw[0] = sq_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    tlrg_sqrt_cell #(.STEP(ROOT_W - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (sv[i]),
      .in_w  (sw[i]),
      .out_v (sv[i+1]),
      .out_w (sw[i+1])
    );
  end

  // ---- dividend stage: mag * 32768 + len / 2
  div_word_t dn_nxt, dn_r;
  logic      vn_r;

  always_comb begin
    dn_nxt.len  = sw[ROOT_W].root;
    dn_nxt.side = sw[ROOT_W].side;
    for (int k = 0; k < 3; k++) begin
      dn_nxt.rem[k] = (NUM_W'(sw[ROOT_W].mag[k]) << 15) + NUM_W'(sw[ROOT_W].root >> 1);
      dn_nxt.quo[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (en) begin
      vn_r <= sv[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r <= dn_nxt;
    end
  end

  // ---- divide chain, one quotient bit per cell
  logic      dv [Q_W+1];
  div_word_t dw [Q_W+1];

  assign dv[0] = vn_r;
  assign dw[0] = dn_r;

  for (genvar i = 0; i < Q_W; i++) begin : g_div
    tlrg_div_cell #(.STEP(Q_W - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (dv[i]),
      .in_w  (dw[i]),
      .out_v (dv[i+1]),
      .out_w (dw[i+1])
    );
  end

  assign last_v = dv[Q_W];

  // ---- output register: sign, clamp at one, zero-vector case
  ray_out_t           res_nxt, out_data_r;
  logic signed [15:0] dir_val [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dw[Q_W].side.neg[k])           dir_val[k] = $signed(16'(-dw[Q_W].quo[k]));
      else if (dw[Q_W].quo[k] > 17'd32767) dir_val[k] = 16'sd32767;
      else                               dir_val[k] = $signed(dw[Q_W].quo[k][15:0]);
    end
    res_nxt.origin_x = dw[Q_W].side.origin_x;
    res_nxt.origin_y = dw[Q_W].side.origin_y;
    res_nxt.origin_z = cam_z_r;
    res_nxt.ray_time = dw[Q_W].side.ray_time;
    if (dw[Q_W].side.zero) begin
      res_nxt.dir_x = 16'sd0;
      res_nxt.dir_y = 16'sd0;
      res_nxt.dir_z = 16'sh8000;
    end else begin
      res_nxt.dir_x = dir_val[0];
      res_nxt.dir_y = dir_val[1];
      res_nxt.dir_z = dir_val[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= last_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // back-pressure reaches the input only through a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && last_v))
    else $error("input stalled without a blocked result");

  // a normalised sum of squares gives a root of at least 2^29
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vn_r && !dn_r.side.zero) |-> (dn_r.len[ROOT_W-1 -: 2] != 2'b00))
    else $error("square root below normalised range");

  // a taken result with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !last_v) |=> !out_valid_r)
    else $error("result repeated");

  // a blocked result and a waiting ray freeze the whole chain
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && last_v) |=> (last_v && $stable(dw[Q_W])))
    else $error("ray lost at chain end");

endmodule

>>> tb/tb.sv
// Self-checking bench for thin_lens_ray_generator_unit: directed and random rays.
// Predicts each ray in-bench and checks it field by field; depends on tlrg_pkg.
module tb;
  import tlrg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ray_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ray_out_t    out_data;

  // bench copy of the camera registers
  logic [31:0] cam_x, cam_y, cam_z, shutter;
  logic [30:0] view_w, view_h, focus, lens_r;

  ray_out_t pending_rays[$];
  int       errors = 0;
  int       cycles = 0;
  int       stall_hold = 0;
  bit       calm_send = 0;
  bit       calm_recv = 0;

  thin_lens_ray_generator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint round_away(longint p, int s);
    longint unsigned m;
    m = ((p < 0) ? -p : p) + (longint'(1) << (s - 1));
    m = m >> s;
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ray_out_t trace_ray(ray_in_t r);
    ray_out_t o;
    longint offx, offy, opn, cls, tm;
    longint d[3];
    longint unsigned a[3], m, sq, len, c;
    logic [15:0] dir[3];
    offx = 0;
    offy = 0;
    if (lens_r != 0) begin
      offx = round_away(longint'(r.disk_x) * longint'(lens_r), 15);
      offy = round_away(longint'(r.disk_y) * longint'(lens_r), 15);
    end
    o.origin_x = 32'(clamp32(longint'($signed(cam_x)) + offx));
    o.origin_y = 32'(clamp32(longint'($signed(cam_y)) + offy));
    o.origin_z = cam_z;
    // difference vector, Q16.32
    d[0] = longint'(view_w) * longint'(r.pixel_u) - longint'(view_w) * 32768 - offx * 65536;
    d[1] = longint'(view_h) * 32768 - longint'(view_h) * longint'(r.pixel_v) - offy * 65536;
    d[2] = -(longint'(focus) * 65536);
    for (int i = 0; i < 3; i++) a[i] = (d[i] < 0) ? -d[i] : d[i];
    m = (a[0] > a[1]) ? a[0] : a[1];
    m = (m > a[2]) ? m : a[2];
    if (m == 0) begin
      dir[0] = 16'h0000;
      dir[1] = 16'h0000;
      dir[2] = 16'h8000;
    end else begin
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      end
      sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      len = floor_root(sq);
      for (int i = 0; i < 3; i++) begin
        c = (a[i] * 32768 + len / 2) / len;
        if (d[i] < 0) dir[i] = 16'(-longint'(c));
        else dir[i] = (c > 32767) ? 16'h7FFF : 16'(c);
      end
    end
    o.dir_x = dir[0];
    o.dir_y = dir[1];
    o.dir_z = dir[2];
    opn = longint'(shutter[31:16]);
    cls = longint'(shutter[15:0]);
    tm = opn + round_away(longint'(r.time_sample) * (cls - opn), 16);
    o.ray_time = 16'(tm);
    return o;
  endfunction

  task automatic flag_field(string name, longint want, longint got);
    errors++;
    $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
  endtask

  // receive side: random stall and checking of each ray word
  always @(posedge clk) begin
    ray_out_t want;
    if ($urandom_range(0, 199) == 0) calm_recv <= ~calm_recv;
    if (stall_hold > 0) begin
      // hold a long stall
      stall_hold <= stall_hold - 1;
      out_stall <= 1'b1;
    end else if (calm_recv) out_stall <= 1'b0;
    else if ($urandom_range(0, 149) == 0) begin
      stall_hold <= $urandom_range(10, 40);
      out_stall <= 1'b1;
    end
    else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
    else if (out_stall && $urandom_range(0, 9) < 3) out_stall <= 1'b0;
    else if ($urandom_range(0, 9) < 2) out_stall <= 1'b1;
    else out_stall <= 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rays.size() == 0) begin
        errors++;
        $display("%0t unexpected ray word: expected none actual %h", $time, out_data);
      end else begin
        want = pending_rays.pop_front();
        if (out_data.origin_x !== want.origin_x)
          flag_field("origin_x", want.origin_x, out_data.origin_x);
        if (out_data.origin_y !== want.origin_y)
          flag_field("origin_y", want.origin_y, out_data.origin_y);
        if (out_data.origin_z !== want.origin_z)
          flag_field("origin_z", want.origin_z, out_data.origin_z);
        if (out_data.dir_x !== want.dir_x) flag_field("dir_x", want.dir_x, out_data.dir_x);
        if (out_data.dir_y !== want.dir_y) flag_field("dir_y", want.dir_y, out_data.dir_y);
        if (out_data.dir_z !== want.dir_z) flag_field("dir_z", want.dir_z, out_data.dir_z);
        if (out_data.ray_time !== want.ray_time)
          flag_field("ray_time", want.ray_time, out_data.ray_time);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CAM_POS_X:      cam_x = val;
      REG_CAM_POS_Y:      cam_y = val;
      REG_CAM_POS_Z:      cam_z = val;
      REG_VIEWPORT_W:     view_w = val[30:0];
      REG_VIEWPORT_H:     view_h = val[30:0];
      REG_FOCUS_DISTANCE: focus = val[30:0];
      REG_LENS_RADIUS:    lens_r = val[30:0];
      default:            shutter = val;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_camera(logic [31:0] px, py, pz, w, h, f, lr, sw);
    write_reg(REG_CAM_POS_X, px);
    write_reg(REG_CAM_POS_Y, py);
    write_reg(REG_CAM_POS_Z, pz);
    write_reg(REG_VIEWPORT_W, w);
    write_reg(REG_VIEWPORT_H, h);
    write_reg(REG_FOCUS_DISTANCE, f);
    write_reg(REG_LENS_RADIUS, lr);
    write_reg(REG_SHUTTER_WINDOW, sw);
  endtask

  // drive one word and hold it until accepted, then at times idle a random while
  task automatic send_ray(ray_in_t r);
    int gap;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_rays.push_back(trace_ray(r));
    if ($urandom_range(0, 99) == 0) calm_send = ~calm_send;
    if (calm_send) gap = 0;
    else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
    else gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rays.size() != 0) @(posedge clk);
  endtask

  function automatic ray_in_t mk_ray(int u, int v, int dx, int dy, int t);
    ray_in_t r;
    r.pixel_u = 17'(u);
    r.pixel_v = 17'(v);
    r.disk_x = 16'(dx);
    r.disk_y = 16'(dy);
    r.time_sample = 16'(t);
    return r;
  endfunction

  function automatic ray_in_t rand_ray();
    ray_in_t r;
    r.pixel_u = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                            : 17'($urandom_range(0, 65536));
    r.pixel_v = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071))
                                            : 17'($urandom_range(0, 65536));
    r.disk_x = 16'($urandom);
    r.disk_y = 16'($urandom);
    r.time_sample = 16'($urandom);
    return r;
  endfunction

  task automatic test_reset_camera();
    // corners, centre and out-of-range coordinates with reset registers
    send_ray(mk_ray(0, 0, 0, 0, 0));
    send_ray(mk_ray(65536, 65536, 32767, -32768, 65535));
    send_ray(mk_ray(32768, 32768, 0, 0, 32768));
    send_ray(mk_ray(131071, 0, -1, 1, 1));
    send_ray(mk_ray(0, 131071, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_lens_and_shutter();
    set_camera(32'h0001_8000, 32'hFFFE_0000, 32'h0003_0000, 32'h0004_0000,
               32'h0003_0000, 32'h0002_0000, 32'h0000_4000, 32'h0100_0380);
    send_ray(mk_ray(0, 65536, -32768, -32768, 65535));
    send_ray(mk_ray(65536, 0, 32767, 32767, 0));
    send_ray(mk_ray(20000, 45000, 12345, -23456, 40000));
    wait_drained();
    // close before open runs time backwards
    write_reg(REG_SHUTTER_WINDOW, 32'hFFFF_0000);
    send_ray(mk_ray(32768, 32768, 1, -1, 65535));
    send_ray(mk_ray(1, 2, -3, 4, 32768));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    // origin saturates both ways, widest viewport, longest focus
    set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_ray(mk_ray(65536, 65536, 32767, -32768, 65535));
    send_ray(mk_ray(0, 0, -32768, 32767, 0));
    send_ray(mk_ray(131071, 131071, 32767, 32767, 12345));
    wait_drained();
    // zero viewport, shortest focus
    set_camera(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1,
               32'h0, 32'h0000_FFFF);
    send_ray(mk_ray(0, 65536, 100, -100, 65535));
    send_ray(mk_ray(65536, 0, 0, 0, 1));
    send_ray(mk_ray(131071, 131071, -32768, -32768, 0));
    wait_drained();
  endtask

  task automatic test_random_rays();
    for (int phase = 0; phase < 6; phase++) begin
      logic [31:0] lr, w, h, f;
      lr = (phase % 3 == 0) ? 32'h0 : (phase == 4 ? $urandom : $urandom_range(0, 32'h8_0000));
      w = (phase == 5) ? $urandom : $urandom_range(0, 32'h10_0000);
      h = (phase == 5) ? $urandom : $urandom_range(0, 32'h10_0000);
      f = (phase == 2) ? $urandom_range(1, 32'h7FFF_FFFF) : $urandom_range(1, 32'h8_0000);
      set_camera($urandom, $urandom, $urandom, w, h, f, lr, $urandom);
      for (int k = 0; k < 90; k++) begin
        send_ray(rand_ray());
        // hold off once until the pipe has emptied
        if (phase == 1 && k == 45) wait_drained();
      end
      wait_drained();
    end
  endtask

  initial begin
    cam_x = '0; cam_y = '0; cam_z = '0; shutter = '0;
    view_w = 31'd131072; view_h = 31'd131072; focus = 31'd65536; lens_r = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_camera();
    test_lens_and_shutter();
    test_register_extremes();
    test_random_rays();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
